// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the stream find-and-replace RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clock outside reset.
`define SFR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising edge of clock outside reset.
`define SFR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sfr_pkg.sv =====
// Types, constants and helpers shared by the stream find-and-replace block.
package sfr_pkg;

   localparam int WIN             = 8;
   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int LEN_W           = $clog2(WIN + 1);
   localparam int IDX_W           = $clog2(WIN);
   localparam int CNT_W           = 16;
   localparam int BYTE_W          = 8;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 64;

   localparam int PLEN_CAP_I = (MAX_PATTERN < WIN) ? MAX_PATTERN : WIN;
   localparam int RLEN_CAP_I = (MAX_REPLACEMENT < WIN) ? MAX_REPLACEMENT : WIN;
   localparam logic [LEN_W-1:0] PLEN_CAP = LEN_W'(PLEN_CAP_I);
   localparam logic [LEN_W-1:0] RLEN_CAP = LEN_W'(RLEN_CAP_I);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_BYTES  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_LENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_ALL        = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              byte_present;
      logic              end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_valid;
      logic              last;
      logic [CNT_W-1:0]  match_count;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_REPL,
      ST_FLUSH,
      ST_MARK
   } ctrl_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic             accept;
      logic             pop;
      logic             repl;
      logic [IDX_W-1:0] repl_idx;
      logic             marker;
      logic             last;
      logic             clear;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic             req_eos;
      logic             dec_match;
      logic [1:0]       dec_npop;
      logic [LEN_W-1:0] dec_fill;
      logic [LEN_W-1:0] fill;
      logic [LEN_W-1:0] rlen;
      logic             out_free;
   } dp_status_type;

   // Clamp a programmed length to the window and to the given limit.
   function automatic logic [LEN_W-1:0] cap_len(input logic [LEN_W-1:0] len,
                                               input logic [LEN_W-1:0] limit);
      logic [LEN_W-1:0] v;
      v = len;
      if (v > LEN_W'(WIN)) v = LEN_W'(WIN);
      if (v > limit) v = limit;
      return v;
   endfunction

endpackage

// ===== hdl/sfr_if.sv =====
// Valid/ready stream interfaces for the request and response channels.
interface sfr_req_if;
   import sfr_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sfr_rsp_if;
   import sfr_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/sfr_ctrl.sv =====
// Controller state machine that sequences acceptance and result emission.
module sfr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sfr_pkg::dp_status_type status,
   output sfr_pkg::dp_cmd_type    cmd
);
   import sfr_pkg::*;

   ctrl_state_type   state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             eos_ff, eos_in;
   logic             repl_final;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         eos_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         eos_ff   <= eos_in;
      end
   end

   assign repl_final = ({1'b0, cnt_ff} + LEN_W'(1)) == status.rlen;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      eos_in    = eos_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               eos_in     = status.req_eos;
               cnt_in     = '0;
               if (status.dec_match) begin
                  if (status.rlen != '0) state_in = ST_REPL;
                  else if (status.req_eos) state_in = ST_MARK;
               end else if (status.req_eos) begin
                  state_in = (status.dec_fill != '0) ? ST_FLUSH : ST_MARK;
               end else if (status.dec_npop != 2'd0) begin
                  cnt_in   = IDX_W'(status.dec_npop);
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            if (status.out_free) begin
               cmd.pop = 1'b1;
               if (cnt_ff == IDX_W'(1)) state_in = ST_IDLE;
               else cnt_in = cnt_ff - IDX_W'(1);
            end
         end
         ST_REPL: begin
            if (status.out_free) begin
               cmd.repl     = 1'b1;
               cmd.repl_idx = cnt_ff;
               cmd.last     = eos_ff && repl_final;
               cmd.clear    = eos_ff && repl_final;
               if (repl_final) state_in = ST_IDLE;
               else cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.pop   = 1'b1;
               cmd.last  = (status.fill == LEN_W'(1));
               cmd.clear = (status.fill == LEN_W'(1));
               if (status.fill == LEN_W'(1)) state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            if (status.out_free) begin
               cmd.marker = 1'b1;
               cmd.last   = 1'b1;
               cmd.clear  = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/sfr_dpath.sv =====
// Datapath: configuration, match window, counters and the result register.
module sfr_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  sfr_pkg::req_payload_type              req_data,
   input  sfr_pkg::dp_cmd_type                   cmd,
   output sfr_pkg::dp_status_type                status,
   output logic                                  rsp_valid,
   output sfr_pkg::rsp_payload_type              rsp_data,
   input  logic                                  rsp_ready
);
   import sfr_pkg::*;

   logic [WIN*BYTE_W-1:0] pat_ff, rep_ff;
   logic [LEN_W-1:0]      plen_raw_ff, rlen_raw_ff;
   logic                  all_ff;

   logic [BYTE_W-1:0]     win_ff [WIN];
   logic [BYTE_W-1:0]     win_in [WIN];
   logic [BYTE_W-1:0]     win_app [WIN];
   logic [LEN_W-1:0]      fill_ff, fill_in;
   logic                  first_ff, first_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic [LEN_W-1:0]      plen, rlen, fill_app, keep, diff;
   logic                  has_room, case_a, full_b, cmp_ok, match;
   logic [1:0]            npop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff      <= '0;
         plen_raw_ff <= '0;
         rep_ff      <= '0;
         rlen_raw_ff <= '0;
         all_ff      <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_BYTES:      pat_ff      <= csr_wdata;
            CSR_PATTERN_LENGTH:     plen_raw_ff <= csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  rep_ff      <= csr_wdata;
            CSR_REPLACEMENT_LENGTH: rlen_raw_ff <= csr_wdata[LEN_W-1:0];
            CSR_REPLACE_ALL:        all_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign plen = cap_len(plen_raw_ff, PLEN_CAP);
   assign rlen = cap_len(rlen_raw_ff, RLEN_CAP);

   // Decision for the byte being offered.
   always_comb begin
      has_room = fill_ff < LEN_W'(WIN);
      fill_app = fill_ff + LEN_W'(has_room);
      for (int i = 0; i < WIN; i++) begin
         win_app[i] = (has_room && fill_ff[IDX_W-1:0] == IDX_W'(i)) ?
                      req_data.in_byte : win_ff[i];
      end
      case_a = (plen == '0) || (fill_ff >= plen);
      keep   = (plen == '0) ? '0 : plen - LEN_W'(1);
      diff   = (fill_app > keep) ? fill_app - keep : '0;
      full_b = (fill_app == plen);
      cmp_ok = 1'b1;
      for (int i = 0; i < WIN; i++) begin
         if (LEN_W'(i) < plen && win_app[i] != pat_ff[BYTE_W*i +: BYTE_W]) cmp_ok = 1'b0;
      end
      match = req_data.byte_present && !case_a && full_b && cmp_ok &&
              (all_ff || !first_ff);
      if (!req_data.byte_present) npop = 2'd0;
      else if (case_a) npop = (diff > LEN_W'(2)) ? 2'd2 : diff[1:0];
      else if (full_b && !match) npop = 2'd1;
      else npop = 2'd0;
   end

   assign status.req_eos   = req_data.end_of_string;
   assign status.dec_match = match;
   assign status.dec_npop  = npop;
   assign status.dec_fill  = match ? '0 : (req_data.byte_present ? fill_app : fill_ff);
   assign status.fill      = fill_ff;
   assign status.rlen      = rlen;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // Window, fill, first-match flag and replacement count.
   always_comb begin
      win_in   = win_ff;
      fill_in  = fill_ff;
      first_in = first_ff;
      count_in = count_ff;
      if (cmd.accept && req_data.byte_present) begin
         win_in  = win_app;
         fill_in = match ? '0 : fill_app;
         if (match) begin
            first_in = 1'b1;
            if (count_ff != '1) count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.pop) begin
         for (int i = 0; i < WIN - 1; i++) win_in[i] = win_ff[i+1];
         win_in[WIN-1] = '0;
         fill_in       = fill_ff - LEN_W'(1);
      end
      if (cmd.clear) begin
         fill_in  = '0;
         first_in = 1'b0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         first_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         first_ff <= first_in;
         count_ff <= count_in;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.pop || cmd.repl || cmd.marker) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_valid   = !cmd.marker;
         rsp_data_in.last        = cmd.last;
         rsp_data_in.match_count = count_ff;
         if (cmd.pop) rsp_data_in.out_byte = win_ff[0];
         else if (cmd.repl) rsp_data_in.out_byte = rep_ff[BYTE_W*cmd.repl_idx +: BYTE_W];
         else rsp_data_in.out_byte = '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/stream_find_replace.sv =====
// Top level of the streaming find-and-replace block.
// This block copies a byte string from the request channel to the response channel,
// replacing leftmost, non-overlapping occurrences of a pattern of up to eight bytes
// with a replacement of up to eight bytes (zero deletes the match), either every
// occurrence or only the first one per string, as set by the configuration registers.
// A request carrying end_of_string flushes the held bytes, marks the final response
// with last (a bare marker with out_valid low if there is nothing to send) and reports
// the saturating replacement count in match_count. The block takes a request, then
// emits the results it causes, one per cycle while the consumer takes them, through a
// single output register, and takes the next request once the last of them is loaded
// into that register. A byte that only enters the match window causes no result, one
// that slides the window one or two, and a replacement or an end-of-string flush up to
// eight. Configuration writes are taken at any time but belong between strings.
module stream_find_replace (
   input  logic                           clock,
   input  logic                           reset,
   sfr_req_if.sink                        req_ch,
   sfr_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sfr_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // The controller decides when a transfer is accepted and which result goes next.
   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // The datapath holds the registers, the window compare and the output register.
   sfr_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_ch.data),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_ch.data),
      .rsp_ready (rsp_ch.ready)
   );

`include "assert_macros.svh"

   // An end-of-string request always yields at least one result, so input holds off.
   `SFR_ASSERT_NXT(a_eos_holds_input, req_ch.valid && req_ch.ready && req_ch.data.end_of_string, !req_ch.ready, "input taken right after an end-of-string transfer")
   // A bare end marker is always the final result of its string.
   `SFR_ASSERT_IMP(a_marker_is_last, rsp_ch.valid && !rsp_ch.data.out_valid, rsp_ch.data.last, "bare marker without last")
   // The controller only loads a result when the output register can take it.
   `SFR_ASSERT_IMP(a_emit_when_free, dp_cmd.pop || dp_cmd.repl || dp_cmd.marker, dp_status.out_free, "result loaded over a pending transfer")
   // The window never holds more bytes than it has places.
   `SFR_ASSERT_IMP(a_fill_bounded, 1'b1, dp_status.fill <= LEN_W'(WIN), "window fill out of range")

endmodule
